// ===== hw/rtl/tdl_pkg.sv =====
package tdl_pkg;

  // Field widths
  localparam int ID_W    = 4;
  localparam int CNT_W   = 5;
  localparam int NUM_IDS = 16;

  // Request codes
  localparam logic [1:0] REQ_CREATE   = 2'd0;
  localparam logic [1:0] REQ_DELETE   = 2'd1;
  localparam logic [1:0] REQ_ACTIVATE = 2'd2;
  localparam logic [1:0] REQ_RUN      = 2'd3;

  // Run kinds held in the kind map
  localparam logic [1:0] KIND_FOREVER = 2'd0;
  localparam logic [1:0] KIND_COND    = 2'd1;
  localparam logic [1:0] KIND_ONCE    = 2'd2;

  // Per-task status codes
  localparam logic [1:0] ST_IDLE      = 2'd0;
  localparam logic [1:0] ST_READY     = 2'd1;
  localparam logic [1:0] ST_SUSPENDED = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic load_req;     // latch the incoming transaction
    logic do_create;    // append id to the tail unless full
    logic do_activate;  // mark id ready
    logic walk_start;   // clear pointers and id mask
    logic rd_issue;     // read list entry at the read pointer
    logic eval_del;     // compact step for delete
    logic eval_count;   // pre-count step of a run pass
    logic count_end;    // latch final length and result budget
    logic eval_run;     // dispatch step of a run pass
    logic walk_end;     // commit compacted length
    logic emit_single;  // single result for create/delete/activate/empty run
  } tdl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [1:0] req_type;
    logic       walk_done;
    logic       len_zero;
    logic       out_free;
    logic       skip;
  } tdl_sts_t;

endpackage

// ===== hw/rtl/tdl_req_if.sv =====
interface tdl_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [3:0] task_id;

  modport source (output valid, req_type, task_id, input ready);
  modport sink   (input valid, req_type, task_id, output ready);
endinterface

// ===== hw/rtl/tdl_rsp_if.sv =====
interface tdl_rsp_if;
  logic       valid;
  logic       ready;
  logic [3:0] out_task_id;
  logic       dispatched;
  logic       status;
  logic [4:0] list_count;
  logic       last;

  modport source (output valid, out_task_id, dispatched, status, list_count, last,
                  input ready);
  modport sink   (input valid, out_task_id, dispatched, status, list_count, last,
                  output ready);
endinterface

// ===== hw/rtl/tdl_ram.sv =====
module tdl_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [$clog2(DEPTH)-1:0]         wr_addr,
  input  logic [WIDTH-1:0]                 wr_data,
  input  logic                             rd_en,
  input  logic [$clog2(DEPTH)-1:0]         rd_addr,
  output logic [WIDTH-1:0]                 rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/tdl_datapath.sv =====
module tdl_datapath #(
  parameter int LIST_CAP = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [31:0]      cfg_wr_data,
  input  logic [1:0]       in_req_type,
  input  logic [3:0]       in_task_id,
  input  tdl_pkg::tdl_cmd_t cmd,
  output tdl_pkg::tdl_sts_t sts,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [3:0]       out_task_id,
  output logic             dispatched,
  output logic             status,
  output logic [4:0]       list_count,
  output logic             last
);
  import tdl_pkg::*;

  localparam int AW = $clog2(LIST_CAP);

  logic [31:0]      run_kind_map;
  logic [1:0]       req_q;
  logic [ID_W-1:0]  id_q;
  logic             full_q;
  logic [CNT_W-1:0] len;
  logic [CNT_W-1:0] rd_ptr;
  logic [CNT_W-1:0] wr_ptr;
  logic [CNT_W-1:0] drop_cnt;
  logic [CNT_W-1:0] ndist;
  logic [CNT_W-1:0] final_len;
  logic [CNT_W-1:0] emit_left;
  logic [1:0]       task_st [NUM_IDS];
  logic [NUM_IDS-1:0] id_mask;

  logic             ram_wr_en;
  logic [AW-1:0]    ram_wr_addr;
  logic [ID_W-1:0]  ram_wr_data;
  logic [ID_W-1:0]  ent;

  logic [1:0]       kind;
  logic [1:0]       ent_st;
  logic             ent_ready;
  logic             once_hit;
  logic             masked;
  logic             keep_run;
  logic             keep_del;
  logic             is_full;
  logic             disp_run;
  logic             run_emit;

  // Ordered list storage
  tdl_ram #(.WIDTH(ID_W), .DEPTH(LIST_CAP)) u_list (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (cmd.rd_issue),
    .rd_addr (rd_ptr[AW-1:0]),
    .rd_data (ent)
  );

  // Entry decode
  always_comb begin
    kind      = run_kind_map[{ent, 1'b0} +: 2];
    ent_st    = task_st[ent];
    ent_ready = (ent_st == ST_READY);
    once_hit  = (kind == KIND_ONCE) && ent_ready;
    masked    = id_mask[ent];
    keep_run  = !masked && !once_hit;
    keep_del  = (ent != id_q);
    is_full   = (len >= CNT_W'(LIST_CAP));
    run_emit  = cmd.eval_run && !masked;
    unique case (kind)
      KIND_FOREVER: disp_run = 1'b1;
      KIND_COND:    disp_run = ent_ready;
      KIND_ONCE:    disp_run = ent_ready;
      default:      disp_run = 1'b0;
    endcase
  end

  // List write port: tail append or compaction
  always_comb begin
    ram_wr_en   = (cmd.do_create && !is_full) || (cmd.eval_del && keep_del) ||
                  (cmd.eval_run && keep_run);
    ram_wr_addr = cmd.do_create ? len[AW-1:0] : wr_ptr[AW-1:0];
    ram_wr_data = cmd.do_create ? id_q : ent;
  end

  // Status to controller
  always_comb begin
    sts.req_type  = req_q;
    sts.walk_done = (rd_ptr == len);
    sts.len_zero  = (len == '0);
    sts.out_free  = !out_valid || out_ready;
    sts.skip      = masked;
  end

  // Control and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      run_kind_map <= '0;
      len          <= '0;
      rd_ptr       <= '0;
      wr_ptr       <= '0;
      drop_cnt     <= '0;
      ndist        <= '0;
      final_len    <= '0;
      emit_left    <= '0;
      id_mask      <= '0;
      full_q       <= 1'b0;
      out_valid    <= 1'b0;
      for (int i = 0; i < NUM_IDS; i++) begin
        task_st[i] <= ST_IDLE;
      end
    end else begin
      if (cfg_wr_en) begin
        run_kind_map <= cfg_wr_data;
      end
      if (cmd.load_req) begin
        full_q <= 1'b0;
      end
      if (cmd.do_create) begin
        full_q <= is_full;
        if (!is_full) begin
          len <= len + CNT_W'(1);
        end
      end
      if (cmd.do_activate) begin
        task_st[id_q] <= ST_READY;
      end
      if (cmd.walk_start) begin
        rd_ptr   <= '0;
        wr_ptr   <= '0;
        drop_cnt <= '0;
        ndist    <= '0;
        id_mask  <= '0;
      end
      if (cmd.eval_del) begin
        rd_ptr <= rd_ptr + CNT_W'(1);
        if (keep_del) begin
          wr_ptr <= wr_ptr + CNT_W'(1);
        end
      end
      // Pre-count: entries dropped and distinct once ids dispatched
      if (cmd.eval_count) begin
        rd_ptr <= rd_ptr + CNT_W'(1);
        if (once_hit) begin
          drop_cnt <= drop_cnt + CNT_W'(1);
          if (!masked) begin
            id_mask[ent] <= 1'b1;
            ndist        <= ndist + CNT_W'(1);
          end
        end
      end
      if (cmd.count_end) begin
        final_len <= len - drop_cnt;
        emit_left <= len - drop_cnt + ndist;
        rd_ptr    <= '0;
        wr_ptr    <= '0;
        id_mask   <= '0;
      end
      // Dispatch step; copies of a removed once id are dropped silently
      if (cmd.eval_run) begin
        rd_ptr <= rd_ptr + CNT_W'(1);
        if (keep_run) begin
          wr_ptr <= wr_ptr + CNT_W'(1);
        end
        if (!masked) begin
          emit_left <= emit_left - CNT_W'(1);
          if (kind == KIND_FOREVER || (kind == KIND_COND && ent_ready)) begin
            task_st[ent] <= ST_IDLE;
          end else if (once_hit) begin
            task_st[ent] <= ST_SUSPENDED;
            id_mask[ent] <= 1'b1;
          end
        end
      end
      if (cmd.walk_end) begin
        len <= wr_ptr;
      end
      if (cmd.emit_single || run_emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_q <= in_req_type;
      id_q  <= in_task_id;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.emit_single) begin
      out_task_id <= (req_q == REQ_RUN) ? '0 : id_q;
      dispatched  <= 1'b0;
      status      <= (req_q == REQ_CREATE) && full_q;
      list_count  <= len;
      last        <= 1'b1;
    end else if (run_emit) begin
      out_task_id <= ent;
      dispatched  <= disp_run;
      status      <= 1'b0;
      list_count  <= final_len;
      last        <= (emit_left == CNT_W'(1));
    end
  end

  a_len_cap: assert property (@(posedge clk) disable iff (rst)
    len <= CNT_W'(LIST_CAP))
    else $error("list length above capacity");

  a_ptr_order: assert property (@(posedge clk) disable iff (rst)
    wr_ptr <= rd_ptr)
    else $error("compaction write pointer passed read pointer");

  a_emit_budget: assert property (@(posedge clk) disable iff (rst)
    run_emit |-> (emit_left != '0))
    else $error("run pass emitted more results than counted");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (list_count == CNT_W'(LIST_CAP)))
    else $error("full status with list below capacity");

endmodule

// ===== hw/rtl/tdl_ctrl.sv =====
module tdl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  tdl_pkg::tdl_sts_t sts,
  output tdl_pkg::tdl_cmd_t cmd
);
  import tdl_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_RESP = 4'd2;
  localparam logic [3:0] S_DRD  = 4'd3;
  localparam logic [3:0] S_DEV  = 4'd4;
  localparam logic [3:0] S_PRD  = 4'd5;
  localparam logic [3:0] S_PEV  = 4'd6;
  localparam logic [3:0] S_RRD  = 4'd7;
  localparam logic [3:0] S_REV  = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // Sequencer: decode, then one list walk for a delete (two for a run pass on a non-empty list)
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_DEC;
        end
      end
      S_DEC: begin
        unique case (sts.req_type)
          REQ_CREATE: begin
            cmd.do_create = 1'b1;
            state_next    = S_RESP;
          end
          REQ_ACTIVATE: begin
            cmd.do_activate = 1'b1;
            state_next      = S_RESP;
          end
          REQ_DELETE: begin
            cmd.walk_start = 1'b1;
            state_next     = S_DRD;
          end
          REQ_RUN: begin
            if (sts.len_zero) begin
              state_next = S_RESP;
            end else begin
              cmd.walk_start = 1'b1;
              state_next     = S_PRD;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.emit_single = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_DRD: begin
        if (sts.walk_done) begin
          cmd.walk_end = 1'b1;
          state_next   = S_RESP;
        end else begin
          cmd.rd_issue = 1'b1;
          state_next   = S_DEV;
        end
      end
      S_DEV: begin
        cmd.eval_del = 1'b1;
        state_next   = S_DRD;
      end
      S_PRD: begin
        if (sts.walk_done) begin
          cmd.count_end = 1'b1;
          state_next    = S_RRD;
        end else begin
          cmd.rd_issue = 1'b1;
          state_next   = S_PEV;
        end
      end
      S_PEV: begin
        cmd.eval_count = 1'b1;
        state_next     = S_PRD;
      end
      S_RRD: begin
        if (sts.walk_done) begin
          cmd.walk_end = 1'b1;
          state_next   = S_IDLE;
        end else begin
          cmd.rd_issue = 1'b1;
          state_next   = S_REV;
        end
      end
      S_REV: begin
        // skipped entries need no output slot
        if (sts.skip || sts.out_free) begin
          cmd.eval_run = 1'b1;
          state_next   = S_RRD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/task_dispatch_list_core.sv =====
// Task dispatch list: ordered list of task ids with a status per task id.
// Channels: req (sink) carries req_type and task_id; rsp (source) carries
// out_task_id, dispatched, status, list_count and last. Both use valid/ready;
// a transaction moves on a clock edge with valid and ready high.
// cfg_wr_en/cfg_wr_data write the 32-bit run kind map (two bits per task id).
// Create, delete and activate give one result; a run pass gives one result per
// visited entry but for copies of a once id it removed, last marking the final
// one. One request is worked at a time: req.ready is high only while the
// sequencer is idle. Create and activate: the request is decoded, then the
// result is loaded. Delete: one list memory read per entry, with a register
// stage on the read data, then the result. Run pass: a counting walk over the
// list, then a dispatch walk that gives the results; the next request is
// taken once the dispatch walk ends.
// The result register lets the sequencer finish the last result and take the
// next request while the receiver holds off; when it stalls a run pass, the
// walk waits on the entry that has a result to give.
// Reset (rst, synchronous) empties the list, sets every task idle and clears
// the kind map; no clearing pass is needed.
module task_dispatch_list_core #(
  parameter int MAX_TASKS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  tdl_req_if.sink     req,
  tdl_rsp_if.source   rsp
);
  import tdl_pkg::*;

  localparam int LIST_CAP = (MAX_TASKS < 16) ? MAX_TASKS : 16;

  tdl_cmd_t cmd;
  tdl_sts_t sts;

  tdl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tdl_datapath #(.LIST_CAP(LIST_CAP)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_req_type (req.req_type),
    .in_task_id  (req.task_id),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .out_task_id (rsp.out_task_id),
    .dispatched  (rsp.dispatched),
    .status      (rsp.status),
    .list_count  (rsp.list_count),
    .last        (rsp.last)
  );

endmodule
